[design/aes_bc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_bc_pkg
// Shared types, S-box tables and round functions for the AES block cipher.
// ----------------------------------------------------------------------------
package aes_bc_pkg;

  localparam int unsigned StoreDepth = 60;
  localparam int unsigned NumStages  = 15;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
  localparam logic [2:0] CFG_KEY_LAST = 3'd4;

  // block command codes
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] GF_POLY    = 8'h1b;

  // key expansion sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOAD   = 3'b010,
    ST_EXPAND = 3'b100
  } exp_state_e;

  typedef logic [0:255][7:0] sbox_tab_t;

  localparam sbox_tab_t SBOX = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // inverse table, built at elaboration from the forward one
  function automatic sbox_tab_t build_inv_sbox();
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam sbox_tab_t INV_SBOX = build_inv_sbox();

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // SubBytes and ShiftRows (or their inverses) over the whole state
  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [1:0]   src;
    logic [7:0]   v;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? 2'(c - r) : 2'(c + r);
        v   = s[127 - 32*src - 8*r -: 8];
        t[127 - 32*c - 8*r -: 8] = inv ? INV_SBOX[v] : SBOX[v];
      end
    end
    return t;
  endfunction

  // MixColumns or InvMixColumns
  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
    logic [127:0]   t;
    logic [3:0][7:0] a, x2, x4, x8;
    logic [7:0]     m0, m1, m2, m3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = s[127 - 32*c - 8*r -: 8];
        x2[r] = xtime(a[r]);
        x4[r] = xtime(x2[r]);
        x8[r] = xtime(x4[r]);
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          m0 = x8[r] ^ x4[r] ^ x2[r];
          m1 = x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4];
          m2 = x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4];
          m3 = x8[(r+3)%4] ^ a[(r+3)%4];
        end else begin
          m0 = x2[r];
          m1 = x2[(r+1)%4] ^ a[(r+1)%4];
          m2 = a[(r+2)%4];
          m3 = a[(r+3)%4];
        end
        t[127 - 32*c - 8*r -: 8] = m0 ^ m1 ^ m2 ^ m3;
      end
    end
    return t;
  endfunction

endpackage

[design/aes_block_cipher_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher_core
// Fully unrolled AES-128/192/256 encrypt/decrypt pipeline with key expansion.
// ----------------------------------------------------------------------------
// Usage:
//   Key registers are written on the cfg channel (index 0 key size, 1..4 the
//   64-bit key words). Every accepted write restarts the key expansion sequencer,
//   which loads the key and then produces one round key word per cycle;
//   in_stall_o stays high until the expansion has finished.
//   Blocks enter on the in channel, one beat per cycle while in_stall_o is low,
//   and leave on the out channel in order. Every beat passes through 15
//   register stages: key whitening, then one per round; shorter keys pass
//   the unused tail stages unchanged. Throughput is one block per cycle while
//   no stall is applied, set by the single pipeline with one round per stage.
//   A stall on the out side freezes the whole pipeline; in_stall_o follows.
//   Reset clears valid bits, key registers and the sequencer; the round key
//   store is undefined until the first key write.
// ----------------------------------------------------------------------------
module aes_block_cipher_core
  import aes_bc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned LastStage = NumStages - 1;

  // configuration registers
  logic [1:0]       key_size_q;
  logic [3:0][63:0] key_bits_q;
  logic             cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && (cfg_index_i <= CFG_KEY_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= '0;
      key_bits_q <= '0;
    end else if (cfg_wr) begin
      if (cfg_index_i == CFG_KEY_SIZE) begin
        key_size_q <= cfg_data_i[1:0];
      end else begin
        key_bits_q[2'(cfg_index_i - 3'd1)] <= cfg_data_i;
      end
    end
  end

  // key geometry; code 3 runs as AES-256
  logic [1:0] ks_eff;
  logic [3:0] nk;
  logic [3:0] nr;
  logic [5:0] total;

  assign ks_eff = (key_size_q == 2'd3) ? 2'd2 : key_size_q;
  assign nk     = 4'd4 + {1'b0, ks_eff, 1'b0};
  assign nr     = nk + 4'd6;
  assign total  = {nk, 2'b00} + 6'd28;

  function automatic logic [31:0] key_word(input logic [3:0][63:0] kb, input logic [2:0] k);
    return k[0] ? kb[k[2:1]][31:0] : kb[k[2:1]][63:32];
  endfunction

  // key expansion sequencer
  exp_state_e       exp_st_q, exp_st_d;
  logic [5:0]       exp_idx_q;
  logic [2:0]       exp_mod_q;
  logic [7:0]       rcon_q;
  logic [7:0][31:0] win_q;
  logic [31:0]      rk_q [StoreDepth];
  logic [31:0]      win_far;
  logic [31:0]      sw_in, sw_out, tmp, new_word;
  logic             mod_zero;

  always_comb begin
    case (ks_eff)
      2'd0:    win_far = win_q[3];
      2'd1:    win_far = win_q[5];
      default: win_far = win_q[7];
    endcase
  end

  assign mod_zero = (exp_mod_q == 3'd0);
  assign sw_in    = mod_zero ? {win_q[0][23:0], win_q[0][31:24]} : win_q[0];
  assign sw_out   = sub_word(sw_in);

  always_comb begin
    if (mod_zero) begin
      tmp = sw_out ^ {rcon_q, 24'h0};
    end else if ((nk == 4'd8) && (exp_mod_q == 3'd4)) begin
      tmp = sw_out;
    end else begin
      tmp = win_q[0];
    end
    new_word = tmp ^ win_far;
  end

  always_comb begin
    exp_st_d = exp_st_q;
    unique case (exp_st_q)
      ST_IDLE:   exp_st_d = ST_IDLE;
      ST_LOAD:   exp_st_d = ST_EXPAND;
      ST_EXPAND: exp_st_d = (exp_idx_q == 6'(StoreDepth - 1)) ? ST_IDLE : ST_EXPAND;
      default:   exp_st_d = ST_IDLE;
    endcase
    if (cfg_wr) begin
      exp_st_d = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_st_q  <= ST_IDLE;
      exp_idx_q <= '0;
      exp_mod_q <= '0;
      rcon_q    <= RCON_FIRST;
    end else begin
      exp_st_q <= exp_st_d;
      if (exp_st_q == ST_LOAD) begin
        exp_idx_q <= {2'b00, nk};
        exp_mod_q <= '0;
        rcon_q    <= RCON_FIRST;
      end else if (exp_st_q == ST_EXPAND) begin
        exp_idx_q <= exp_idx_q + 6'd1;
        exp_mod_q <= (exp_mod_q == 3'(nk - 4'd1)) ? 3'd0 : exp_mod_q + 3'd1;
        if (mod_zero) begin
          rcon_q <= xtime(rcon_q);
        end
      end
    end
  end

  // round key store and sliding window of the last eight words
  always_ff @(posedge clk_i) begin
    if (exp_st_q == ST_LOAD) begin
      for (int k = 0; k < 8; k++) begin
        rk_q[k]  <= key_word(key_bits_q, 3'(k));
        win_q[k] <= key_word(key_bits_q, 3'(nk - 4'd1 - 4'(k)));
      end
    end else if (exp_st_q == ST_EXPAND) begin
      rk_q[exp_idx_q] <= (exp_idx_q >= total) ? 32'h0 : new_word;
      win_q           <= {win_q[6:0], new_word};
    end
  end

  logic [127:0] rk_blk [NumStages];
  for (genvar k = 0; k < NumStages; k++) begin : g_rk
    assign rk_blk[k] = {rk_q[4*k], rk_q[4*k+1], rk_q[4*k+2], rk_q[4*k+3]};
  end

  // pipeline: stage 0 whitening, stages 1..14 one round each
  logic         adv;
  logic         pipe_vld_q [NumStages];
  logic         pipe_cmd_q [NumStages];
  logic [127:0] pipe_st_q  [NumStages];
  logic [127:0] pipe_st_d  [NumStages];

  assign adv         = !(pipe_vld_q[LastStage] && out_stall_i);
  assign in_stall_o  = (exp_st_q != ST_IDLE) || !adv;

  always_comb begin
    logic [127:0] key0;
    case (ks_eff)
      2'd0:    key0 = rk_blk[10];
      2'd1:    key0 = rk_blk[12];
      default: key0 = rk_blk[14];
    endcase
    if (command_i == CMD_ENCRYPT) begin
      key0 = rk_blk[0];
    end
    pipe_st_d[0] = {block_high_i, block_low_i} ^ key0;
  end

  for (genvar j = 1; j < NumStages; j++) begin : g_round
    localparam int D10 = (j <= 10) ? 10 - j : 0;
    localparam int D12 = (j <= 12) ? 12 - j : 0;
    localparam int D14 = 14 - j;

    always_comb begin
      logic [127:0] key, ss, ak;
      case (ks_eff)
        2'd0:    key = rk_blk[D10];
        2'd1:    key = rk_blk[D12];
        default: key = rk_blk[D14];
      endcase
      if (pipe_cmd_q[j-1] == CMD_ENCRYPT) begin
        key = rk_blk[j];
      end
      ss = sub_shift(pipe_st_q[j-1], pipe_cmd_q[j-1]);
      ak = ss ^ key;
      if (4'(j) > nr) begin
        pipe_st_d[j] = pipe_st_q[j-1];
      end else if (4'(j) == nr) begin
        pipe_st_d[j] = ak;
      end else if (pipe_cmd_q[j-1] == CMD_DECRYPT) begin
        pipe_st_d[j] = mix_cols(ak, 1'b1);
      end else begin
        pipe_st_d[j] = mix_cols(ss, 1'b0) ^ key;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NumStages; j++) begin
        pipe_vld_q[j] <= 1'b0;
      end
    end else if (adv) begin
      pipe_vld_q[0] <= in_valid_i && !in_stall_o;
      for (int j = 1; j < NumStages; j++) begin
        pipe_vld_q[j] <= pipe_vld_q[j-1];
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_cmd_q[0] <= command_i;
      pipe_st_q[0]  <= pipe_st_d[0];
      for (int j = 1; j < NumStages; j++) begin
        pipe_cmd_q[j] <= pipe_cmd_q[j-1];
        pipe_st_q[j]  <= pipe_st_d[j];
      end
    end
  end

  assign out_valid_o   = pipe_vld_q[LastStage];
  assign result_high_o = pipe_st_q[LastStage][127:64];
  assign result_low_o  = pipe_st_q[LastStage][63:0];

  // checks
  a_exp_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_st_q == ST_EXPAND) |-> ((exp_idx_q >= {2'b00, nk}) &&
                                 (exp_idx_q < 6'(StoreDepth))))
    else $error("key expansion index out of range");

  a_load_to_expand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((exp_st_q == ST_LOAD) && !cfg_wr) |=> (exp_st_q == ST_EXPAND))
    else $error("key load not followed by expansion");

  a_rcon_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_st_q == ST_EXPAND) |-> (rcon_q != 8'h00))
    else $error("round constant collapsed to zero");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_vld_q[0] && !adv) |=> pipe_vld_q[0])
    else $error("first stage lost a beat under stall");

endmodule
